>>> design/prrs_pkg.sv
// Shared types and constants for the priority round-robin scheduler.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package prrs_pkg;

    localparam int TID_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int SLICE_W = 32;
    localparam int TIME_W  = 64;
    localparam int CNT_W   = 5;

    typedef enum logic [2:0] {
        CMD_ADMIT  = 3'd0,
        CMD_RETIRE = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_YIELD  = 3'd3,
        CMD_CHOOSE = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_EXISTS  = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_CHARGE,
        S_REFILL,
        S_PICK,
        S_FINAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               used;
        logic               ready;
        logic [TID_W-1:0]   thread;
        logic [PRIO_W-1:0]  prio;
        logic [SLICE_W-1:0] remaining;
        logic [TIME_W-1:0]  order;
    } t_slot;

endpackage

>>> design/prrs_slot_table.sv
// Slot table of the scheduler: one entry per slot, one read/write index.
// Depends on prrs_pkg for the entry layout.
`timescale 1ns / 1ps

module prrs_slot_table #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [IW-1:0]  i_idx,
    input  logic           i_we,
    input  prrs_pkg::t_slot i_wdata,
    output prrs_pkg::t_slot o_rdata
);

    prrs_pkg::t_slot r_slot [SLOTS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (!i_rst_n) begin
                r_slot[i].used  <= 1'b0;
                r_slot[i].ready <= 1'b0;
            end else if (i_we && (i_idx == IW'(i))) begin
                r_slot[i] <= i_wdata;
            end
        end
    end

    // Read the addressed slot; an index past the table reads as empty.
    always_comb begin
        o_rdata = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_idx == IW'(i)) begin
                o_rdata = r_slot[i];
            end
        end
    end

endmodule

>>> design/priority_round_robin_scheduler.sv
// Strict-priority round-robin thread scheduler over a table of SLOTS slots.
// Each input beat is one command (admit, retire, update, yield, choose, query)
// and yields exactly one result beat. A sequencer walks the slot table one
// slot per cycle through a single read/write port: every command takes a
// lookup walk and a counting walk; table edits and queries put an apply step
// between the two, while choose puts a charge step, a refill walk and a pick
// walk there instead. The input is not ready while a command is in
// progress. The result waits in an output register; the next command is
// taken as soon as the block is back in idle.
// Depends on prrs_pkg and prrs_slot_table.
`timescale 1ns / 1ps

module priority_round_robin_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: slice_length_ns
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    // command beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // thread_id[15:0], runnable_flag[16], priority_req[24:17], now_ns[88:25]
    input  logic [95:0]  s_axis_tdata,
    // command[2:0]
    input  logic [2:0]   s_axis_tuser,
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], next_thread[18:3], timer_ns[50:19], preempted[51],
    // slice_left_ns[83:52], queried_runnable[84], admitted_count[89:85],
    // runnable_count[94:90], running_thread[110:95]
    output logic [111:0] m_axis_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    localparam int TW = prrs_pkg::TID_W;
    localparam int PW = prrs_pkg::PRIO_W;
    localparam int LW = prrs_pkg::SLICE_W;
    localparam int NW = prrs_pkg::TIME_W;

    prrs_pkg::t_state  r_state, n_state;
    prrs_pkg::t_cmd    r_cmd, n_cmd;
    prrs_pkg::t_status r_status, n_status;

    logic [TW-1:0] r_tid, n_tid;
    logic          r_flag, n_flag;
    logic [PW-1:0] r_prio, n_prio;
    logic [NW-1:0] r_now, n_now;
    logic [IW-1:0] r_idx, n_idx;

    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic          r_free, n_free;
    logic [IW-1:0] r_free_idx, n_free_idx;

    logic [CW-1:0] r_used_cnt, n_used_cnt;
    logic [CW-1:0] r_run_cnt, n_run_cnt;
    logic [TW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_last, n_last;
    logic          r_decided, n_decided;
    logic [NW-1:0] r_order_ctr, n_order_ctr;
    logic [LW-1:0] r_slice;

    logic          r_pk_ok, n_pk_ok;
    logic [PW-1:0] r_pk_prio, n_pk_prio;
    logic [NW-1:0] r_pk_order, n_pk_order;
    logic [TW-1:0] r_pk_thread, n_pk_thread;
    logic [LW-1:0] r_pk_rem, n_pk_rem;
    logic          r_prev_ready, n_prev_ready;
    logic          r_peer, n_peer;
    logic [LW-1:0] r_q_rem, n_q_rem;
    logic          r_q_rdy, n_q_rdy;

    logic          r_out_valid, n_out_valid;
    logic [111:0]  r_out_data, n_out_data;

    logic            tbl_we;
    prrs_pkg::t_slot tbl_wdata;
    prrs_pkg::t_slot slot;

    prrs_slot_table #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_we    (tbl_we),
        .i_wdata (tbl_wdata),
        .o_rdata (slot)
    );

    // Lookup key: choose looks up the running thread, everything else the
    // thread named by the command. Thread zero never matches.
    logic [TW-1:0] key;
    logic          match;
    assign key   = (r_cmd == prrs_pkg::CMD_CHOOSE) ? r_cur : r_tid;
    assign match = slot.used && (slot.thread == key) && (key != '0);

    // Charge: elapsed time since the last choose, zero if time went back.
    logic [NW-1:0] elapsed;
    logic [LW-1:0] charged;
    assign elapsed = (r_now >= r_last) ? (r_now - r_last) : '0;
    assign charged = (elapsed >= {{(NW-LW){1'b0}}, slot.remaining}) ?
                     '0 : (slot.remaining - elapsed[LW-1:0]);

    // Pick compare against the best slot so far.
    logic better;
    assign better = !r_pk_ok || (slot.prio > r_pk_prio) ||
                    ((slot.prio == r_pk_prio) && (slot.order < r_pk_order));

    logic          scan_end;
    logic [TW-1:0] next_thread;
    logic          preempted;
    logic [LW-1:0] timer;
    assign scan_end    = (r_idx == LAST_IDX);
    assign next_thread = r_pk_ok ? r_pk_thread : '0;
    assign preempted   = (r_cur != '0) && (r_cur != next_thread) && r_prev_ready;
    assign timer       = (r_pk_ok && r_peer) ? r_pk_rem : '0;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == prrs_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_tid        = r_tid;
        n_flag       = r_flag;
        n_prio       = r_prio;
        n_now        = r_now;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_used_cnt   = r_used_cnt;
        n_run_cnt    = r_run_cnt;
        n_cur        = r_cur;
        n_last       = r_last;
        n_decided    = r_decided;
        n_order_ctr  = r_order_ctr;
        n_pk_ok      = r_pk_ok;
        n_pk_prio    = r_pk_prio;
        n_pk_order   = r_pk_order;
        n_pk_thread  = r_pk_thread;
        n_pk_rem     = r_pk_rem;
        n_prev_ready = r_prev_ready;
        n_peer       = r_peer;
        n_q_rem      = r_q_rem;
        n_q_rdy      = r_q_rdy;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        tbl_we       = 1'b0;
        tbl_wdata    = slot;

        case (r_state)
            prrs_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    // Latch the command beat and start the lookup walk.
                    n_cmd    = prrs_pkg::t_cmd'(s_axis_tuser);
                    n_tid    = s_axis_tdata[15:0];
                    n_flag   = s_axis_tdata[16];
                    n_prio   = s_axis_tdata[24:17];
                    n_now    = s_axis_tdata[88:25];
                    n_status = prrs_pkg::ST_OK;
                    n_q_rem  = '0;
                    n_q_rdy  = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_idx    = '0;
                    n_state  = prrs_pkg::S_FIND;
                end
            end

            prrs_pkg::S_FIND: begin
                if (match && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!slot.used && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (scan_end) begin
                    if (r_cmd == prrs_pkg::CMD_CHOOSE) begin
                        n_idx   = n_hit_idx;
                        n_state = prrs_pkg::S_CHARGE;
                    end else begin
                        n_idx   = (r_cmd == prrs_pkg::CMD_ADMIT) ? n_free_idx : n_hit_idx;
                        n_state = prrs_pkg::S_APPLY;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            prrs_pkg::S_APPLY: begin
                case (r_cmd)
                    prrs_pkg::CMD_ADMIT: begin
                        if (r_tid == '0) begin
                            n_status = prrs_pkg::ST_INVALID;
                        end else if (r_hit) begin
                            n_status = prrs_pkg::ST_EXISTS;
                        end else if (!r_free) begin
                            n_status = prrs_pkg::ST_FULL;
                        end else begin
                            tbl_we              = 1'b1;
                            tbl_wdata.used      = 1'b1;
                            tbl_wdata.ready     = 1'b1;
                            tbl_wdata.thread    = r_tid;
                            tbl_wdata.prio      = r_prio;
                            tbl_wdata.remaining = r_slice;
                            tbl_wdata.order     = r_order_ctr;
                            n_order_ctr         = r_order_ctr + 1'b1;
                            n_used_cnt          = r_used_cnt + 1'b1;
                        end
                    end
                    prrs_pkg::CMD_RETIRE,
                    prrs_pkg::CMD_UPDATE,
                    prrs_pkg::CMD_YIELD: begin
                        if (r_tid == '0) begin
                            n_status = prrs_pkg::ST_INVALID;
                        end else if (!r_hit) begin
                            n_status = prrs_pkg::ST_UNKNOWN;
                        end else begin
                            tbl_we = 1'b1;
                            if (r_cmd == prrs_pkg::CMD_RETIRE) begin
                                // Drop the slot; the running thread is not charged.
                                tbl_wdata = '0;
                                if (r_used_cnt != '0) begin
                                    n_used_cnt = r_used_cnt - 1'b1;
                                end
                                if (r_cur == r_tid) begin
                                    n_cur = '0;
                                end
                            end else if (r_cmd == prrs_pkg::CMD_UPDATE) begin
                                tbl_wdata.ready = r_flag;
                                tbl_wdata.prio  = r_prio;
                            end else begin
                                tbl_wdata.remaining = '0;
                            end
                        end
                    end
                    prrs_pkg::CMD_QUERY: begin
                        if (!r_hit) begin
                            n_status = prrs_pkg::ST_UNKNOWN;
                        end else begin
                            n_q_rem = slot.remaining;
                            n_q_rdy = slot.ready;
                        end
                    end
                    default: begin
                    end
                endcase
                n_idx     = '0;
                n_run_cnt = '0;
                n_peer    = 1'b0;
                n_pk_ok   = 1'b0;
                n_state   = prrs_pkg::S_FINAL;
            end

            prrs_pkg::S_CHARGE: begin
                if (r_decided && r_hit) begin
                    tbl_we              = 1'b1;
                    tbl_wdata.remaining = charged;
                end
                n_idx   = '0;
                n_state = prrs_pkg::S_REFILL;
            end

            prrs_pkg::S_REFILL: begin
                // Exhausted slices get a full slice and a fresh sequence number.
                if (slot.used && (slot.remaining == '0)) begin
                    tbl_we              = 1'b1;
                    tbl_wdata.remaining = r_slice;
                    tbl_wdata.order     = r_order_ctr;
                    n_order_ctr         = r_order_ctr + 1'b1;
                end
                if (scan_end) begin
                    n_idx        = '0;
                    n_pk_ok      = 1'b0;
                    n_prev_ready = 1'b0;
                    n_state      = prrs_pkg::S_PICK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            prrs_pkg::S_PICK: begin
                if (slot.used && slot.ready && better) begin
                    n_pk_ok     = 1'b1;
                    n_pk_prio   = slot.prio;
                    n_pk_order  = slot.order;
                    n_pk_thread = slot.thread;
                    n_pk_rem    = slot.remaining;
                end
                // Note whether the previous thread is still runnable.
                if (slot.used && (r_cur != '0) && (slot.thread == r_cur)) begin
                    n_prev_ready = slot.ready;
                end
                if (scan_end) begin
                    n_idx     = '0;
                    n_run_cnt = '0;
                    n_peer    = 1'b0;
                    n_state   = prrs_pkg::S_FINAL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            prrs_pkg::S_FINAL: begin
                if (slot.used && slot.ready) begin
                    n_run_cnt = r_run_cnt + 1'b1;
                    // A runnable peer at the chosen priority arms the timer.
                    if (r_pk_ok && (slot.thread != r_pk_thread) &&
                        (slot.prio == r_pk_prio)) begin
                        n_peer = 1'b1;
                    end
                end
                if (scan_end) begin
                    n_state = prrs_pkg::S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            prrs_pkg::S_OUT: begin
                // Hold here until the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    if (r_cmd == prrs_pkg::CMD_CHOOSE) begin
                        n_cur      = next_thread;
                        n_last     = r_now;
                        n_decided  = 1'b1;
                        n_out_data = {1'b0, next_thread, 5'(r_run_cnt), 5'(r_used_cnt),
                                      1'b0, {LW{1'b0}}, preempted, timer,
                                      next_thread, r_status};
                    end else begin
                        n_out_data = {1'b0, r_cur, 5'(r_run_cnt), 5'(r_used_cnt),
                                      r_q_rdy, r_q_rem, 1'b0, {LW{1'b0}},
                                      {TW{1'b0}}, r_status};
                    end
                    n_state = prrs_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prrs_pkg::S_IDLE;
            r_used_cnt  <= '0;
            r_cur       <= '0;
            r_last      <= '0;
            r_decided   <= 1'b0;
            r_order_ctr <= '0;
            r_slice     <= 32'd10000000;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used_cnt  <= n_used_cnt;
            r_cur       <= n_cur;
            r_last      <= n_last;
            r_decided   <= n_decided;
            r_order_ctr <= n_order_ctr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_slice <= i_cfg_data;
            end
        end
    end

    // Working registers of the walk; valid only while a command is active.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_status     <= n_status;
        r_tid        <= n_tid;
        r_flag       <= n_flag;
        r_prio       <= n_prio;
        r_now        <= n_now;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_free       <= n_free;
        r_free_idx   <= n_free_idx;
        r_run_cnt    <= n_run_cnt;
        r_pk_ok      <= n_pk_ok;
        r_pk_prio    <= n_pk_prio;
        r_pk_order   <= n_pk_order;
        r_pk_thread  <= n_pk_thread;
        r_pk_rem     <= n_pk_rem;
        r_prev_ready <= n_prev_ready;
        r_peer       <= n_peer;
        r_q_rem      <= n_q_rem;
        r_q_rdy      <= n_q_rdy;
        r_out_data   <= n_out_data;
    end

endmodule

>>> test/prrs_scoreboard.sv
// Scheduler scoreboard: watches the config, command and result channels,
// predicts every result beat from its own copy of the slot table and compares.
// Depends on prrs_pkg for widths, command and status codes.
`timescale 1ns / 1ps

module prrs_scoreboard #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_cmd_valid,
    input  logic         i_cmd_ready,
    input  logic [95:0]  i_cmd_data,
    input  logic [2:0]   i_cmd_user,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [111:0] i_res_data,
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        prrs_pkg::t_status                 status;
        logic [prrs_pkg::TID_W-1:0]        next_thread;
        logic [prrs_pkg::SLICE_W-1:0]      timer_ns;
        logic                              preempted;
        logic [prrs_pkg::SLICE_W-1:0]      slice_left_ns;
        logic                              queried_runnable;
        logic [prrs_pkg::CNT_W-1:0]        admitted_count;
        logic [prrs_pkg::CNT_W-1:0]        runnable_count;
        logic [prrs_pkg::TID_W-1:0]        running_thread;
    } t_sched_result;

    // predicted scheduler state
    logic [prrs_pkg::SLICE_W-1:0] slice_len;
    logic                         tbl_used   [SLOTS];
    logic [prrs_pkg::TID_W-1:0]   tbl_thread [SLOTS];
    logic [prrs_pkg::PRIO_W-1:0]  tbl_prio   [SLOTS];
    logic                         tbl_ready  [SLOTS];
    logic [prrs_pkg::SLICE_W-1:0] tbl_left   [SLOTS];
    logic [prrs_pkg::TIME_W-1:0]  tbl_seq    [SLOTS];
    logic [prrs_pkg::CNT_W-1:0]   admitted;
    logic [prrs_pkg::TID_W-1:0]   running;
    logic [prrs_pkg::TIME_W-1:0]  last_choose_ns;
    logic                         chose_once;
    logic [prrs_pkg::TIME_W-1:0]  seq_counter;

    t_sched_result expected_results[$];
    int            mismatches;

    function automatic int find_slot(logic [prrs_pkg::TID_W-1:0] tid);
        if (tid == '0) return -1;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_thread[i] == tid) return i;
        return -1;
    endfunction

    function automatic void clear_entry(int i);
        tbl_used[i]   = 1'b0;
        tbl_thread[i] = '0;
        tbl_prio[i]   = '0;
        tbl_ready[i]  = 1'b0;
        tbl_left[i]   = '0;
        tbl_seq[i]    = '0;
    endfunction

    task automatic reset_table();
        slice_len = 32'd10000000;
        for (int i = 0; i < SLOTS; i++) clear_entry(i);
        admitted       = '0;
        running        = '0;
        last_choose_ns = '0;
        chose_once     = 1'b0;
        seq_counter    = '0;
    endtask

    function automatic void run_choose(logic [prrs_pkg::TIME_W-1:0] now,
                                       inout t_sched_result r);
        int                           pick;
        int                           c;
        logic [prrs_pkg::TIME_W-1:0]  elapsed;
        logic [prrs_pkg::TID_W-1:0]   prev;
        logic [prrs_pkg::TID_W-1:0]   next;
        pick = -1;
        prev = running;
        // charge the running thread, nothing if time went backwards
        if (chose_once && running != '0) begin
            c = find_slot(running);
            if (c >= 0) begin
                elapsed = (now >= last_choose_ns) ? now - last_choose_ns : '0;
                tbl_left[c] = (elapsed >= {32'd0, tbl_left[c]}) ? '0
                                                                : tbl_left[c] - elapsed[31:0];
            end
        end
        // refill exhausted slices with a fresh round-robin position
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i] && tbl_left[i] == '0) begin
                tbl_left[i] = slice_len;
                tbl_seq[i]  = seq_counter;
                seq_counter++;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_used[i] || !tbl_ready[i]) continue;
            if (pick < 0 || tbl_prio[i] > tbl_prio[pick] ||
                (tbl_prio[i] == tbl_prio[pick] && tbl_seq[i] < tbl_seq[pick]))
                pick = i;
        end
        next = (pick < 0) ? '0 : tbl_thread[pick];
        if (prev != '0 && prev != next) begin
            c = find_slot(prev);
            r.preempted = (c >= 0) && tbl_ready[c];
        end
        // arm the timer only when an equal-priority peer is runnable
        if (pick >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_used[i] && tbl_ready[i] && tbl_thread[i] != next &&
                    tbl_prio[i] == tbl_prio[pick]) begin
                    r.timer_ns = tbl_left[pick];
                    break;
                end
            end
        end
        running        = next;
        last_choose_ns = now;
        chose_once     = 1'b1;
        r.next_thread  = next;
    endfunction

    function automatic t_sched_result predict_result(logic [2:0] cmd,
                                                     logic [prrs_pkg::TID_W-1:0] tid,
                                                     logic flag,
                                                     logic [prrs_pkg::PRIO_W-1:0] prio,
                                                     logic [prrs_pkg::TIME_W-1:0] now);
        t_sched_result r;
        int            s;
        int            rc;
        r = '{status: prrs_pkg::ST_OK, default: '0};
        rc = 0;
        case (cmd)
            prrs_pkg::CMD_ADMIT: begin
                if (tid == '0) r.status = prrs_pkg::ST_INVALID;
                else if (find_slot(tid) >= 0) r.status = prrs_pkg::ST_EXISTS;
                else begin
                    r.status = prrs_pkg::ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_used[i]) continue;
                        tbl_used[i]   = 1'b1;
                        tbl_thread[i] = tid;
                        tbl_prio[i]   = prio;
                        tbl_ready[i]  = 1'b1;
                        tbl_left[i]   = slice_len;
                        tbl_seq[i]    = seq_counter;
                        seq_counter++;
                        admitted++;
                        r.status = prrs_pkg::ST_OK;
                        break;
                    end
                end
            end
            prrs_pkg::CMD_RETIRE, prrs_pkg::CMD_UPDATE, prrs_pkg::CMD_YIELD: begin
                s = find_slot(tid);
                if (tid == '0) r.status = prrs_pkg::ST_INVALID;
                else if (s < 0) r.status = prrs_pkg::ST_UNKNOWN;
                else if (cmd == prrs_pkg::CMD_RETIRE) begin
                    clear_entry(s);
                    if (admitted != '0) admitted--;
                    if (running == tid) running = '0;
                end else if (cmd == prrs_pkg::CMD_UPDATE) begin
                    tbl_ready[s] = flag;
                    tbl_prio[s]  = prio;
                end else begin
                    tbl_left[s] = '0;
                end
            end
            prrs_pkg::CMD_CHOOSE: run_choose(now, r);
            prrs_pkg::CMD_QUERY: begin
                s = find_slot(tid);
                if (s < 0) r.status = prrs_pkg::ST_UNKNOWN;
                else begin
                    r.slice_left_ns    = tbl_left[s];
                    r.queried_runnable = tbl_ready[s];
                end
            end
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_ready[i]) rc++;
        r.admitted_count = admitted;
        r.runnable_count = rc[prrs_pkg::CNT_W-1:0];
        r.running_thread = running;
        return r;
    endfunction

    function automatic t_sched_result unpack_result(logic [111:0] d);
        t_sched_result r;
        r.status           = prrs_pkg::t_status'(d[2:0]);
        r.next_thread      = d[18:3];
        r.timer_ns         = d[50:19];
        r.preempted        = d[51];
        r.slice_left_ns    = d[83:52];
        r.queried_runnable = d[84];
        r.admitted_count   = d[89:85];
        r.runnable_count   = d[94:90];
        r.running_thread   = d[110:95];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (!i_rst_n) begin
            reset_table();
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = unpack_result(i_res_data);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: %p", $realtime, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.next_thread != want.next_thread ||
                        got.timer_ns != want.timer_ns || got.preempted != want.preempted ||
                        got.slice_left_ns != want.slice_left_ns ||
                        got.queried_runnable != want.queried_runnable ||
                        got.admitted_count != want.admitted_count ||
                        got.runnable_count != want.runnable_count ||
                        got.running_thread != want.running_thread) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) slice_len = i_cfg_data;
            if (i_cmd_valid && i_cmd_ready)
                expected_results.push_back(predict_result(i_cmd_user, i_cmd_data[15:0],
                                                          i_cmd_data[16], i_cmd_data[24:17],
                                                          i_cmd_data[88:25]));
        end
        o_errors  <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule

>>> test/tb_priority_round_robin_scheduler.sv
// Stimulus and verdict for the priority round-robin scheduler.
// Depends on prrs_pkg, the scheduler RTL and prrs_scoreboard.
`timescale 1ns / 1ps

module tb_priority_round_robin_scheduler;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  PHASE_ITEMS = 125;
    localparam int  HOLD_CYCLES = 400;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;

    int           errors;
    int           pending;
    int           cycles = 0;
    // idle percentages for the sender and for the receiver
    int           send_idle_pct;
    int           recv_stall_pct;
    // bump to request one long receiver hold-off
    int           hold_requests;
    int           hold_served = 0;
    int           hold_left = 0;
    logic [prrs_pkg::TIME_W-1:0] clock_ns;

    priority_round_robin_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    prrs_scoreboard scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd_ready (s_axis_tready),
        .i_cmd_data  (s_axis_tdata),
        .i_cmd_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up if the run hangs anywhere.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so that the
    // result register stays full and the block backs up its command input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            m_axis_tready  <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served    <= hold_requests;
            hold_left      <= HOLD_CYCLES;
            m_axis_tready  <= 1'b0;
        end else begin
            m_axis_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Present one command beat and hold it until accepted.
    task automatic send_beat(prrs_pkg::t_cmd cmd, logic [prrs_pkg::TID_W-1:0] tid,
                             logic flag, logic [prrs_pkg::PRIO_W-1:0] prio,
                             logic [prrs_pkg::TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {7'd0, now, prio, flag, tid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drain every result, let the block settle, then write the slice length.
    task automatic write_slice(logic [31:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [prrs_pkg::TID_W-1:0] pick_tid();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return '0;
        if (roll < 88) return prrs_pkg::TID_W'($urandom_range(1, 20));
        return prrs_pkg::TID_W'($urandom);
    endfunction

    function automatic logic [prrs_pkg::PRIO_W-1:0] pick_prio();
        if ($urandom_range(99) < 80) return prrs_pkg::PRIO_W'($urandom_range(0, 3));
        return prrs_pkg::PRIO_W'($urandom);
    endfunction

    // Mostly small forward steps; sometimes backwards or a wild jump.
    task automatic advance_clock();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6) clock_ns = clock_ns - $urandom_range(1, 200);
        else if (roll < 9) clock_ns = {$urandom, $urandom};
        else clock_ns = clock_ns + $urandom_range(0, 150);
    endtask

    task automatic send_random();
        int             roll;
        prrs_pkg::t_cmd cmd;
        roll = $urandom_range(99);
        if (roll < 20) cmd = prrs_pkg::CMD_ADMIT;
        else if (roll < 30) cmd = prrs_pkg::CMD_RETIRE;
        else if (roll < 45) cmd = prrs_pkg::CMD_UPDATE;
        else if (roll < 55) cmd = prrs_pkg::CMD_YIELD;
        else if (roll < 85) cmd = prrs_pkg::CMD_CHOOSE;
        else cmd = prrs_pkg::CMD_QUERY;
        if (cmd == prrs_pkg::CMD_CHOOSE) advance_clock();
        // fields a command ignores still carry random bits
        send_beat(cmd, pick_tid(), ($urandom_range(99) < 75), pick_prio(),
                  (cmd == prrs_pkg::CMD_CHOOSE) ? clock_ns : {$urandom, $urandom});
    endtask

    // Hold off the receiver right as the phase starts sending, if asked.
    task automatic run_phase(int send_pct, int recv_pct, logic [31:0] slice, bit hold_off);
        write_slice(slice);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold_off) hold_requests = hold_requests + 1;
        repeat (PHASE_ITEMS) send_random();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = prrs_pkg::CMD_ADMIT;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        clock_ns       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: invalid ids, unknown threads, duplicates, extremes.
        send_beat(prrs_pkg::CMD_ADMIT,  16'd0,    1'b1, 8'd9,  '0);
        send_beat(prrs_pkg::CMD_ADMIT,  16'hFFFF, 1'b0, 8'hFF, '1);
        send_beat(prrs_pkg::CMD_ADMIT,  16'hFFFF, 1'b1, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_QUERY,  16'd0,    1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_QUERY,  16'd1234, 1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_RETIRE, 16'd0,    1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_UPDATE, 16'd0,    1'b1, 8'd5,  '0);
        send_beat(prrs_pkg::CMD_YIELD,  16'd0,    1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_CHOOSE, 16'd0,    1'b0, 8'd0,  64'd0);
        // fill the table at one priority, then overflow it
        for (int t = 1; t <= 15; t++)
            send_beat(prrs_pkg::CMD_ADMIT, prrs_pkg::TID_W'(t), 1'b1, 8'd255, '0);
        send_beat(prrs_pkg::CMD_ADMIT,  16'd100,  1'b1, 8'd1,  '0);
        send_beat(prrs_pkg::CMD_CHOOSE, 16'd0,    1'b0, 8'd0,  64'd20000000);
        send_beat(prrs_pkg::CMD_YIELD,  16'hFFFF, 1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_CHOOSE, 16'd0,    1'b0, 8'd0,  64'd5);
        send_beat(prrs_pkg::CMD_UPDATE, 16'd1,    1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_CHOOSE, 16'd0,    1'b0, 8'hFF, '1);
        send_beat(prrs_pkg::CMD_RETIRE, 16'hFFFF, 1'b0, 8'd0,  '0);
        send_beat(prrs_pkg::CMD_QUERY,  16'd2,    1'b0, 8'd0,  '0);

        // Random phases; the long receiver hold-off opens the first one.
        run_phase(0,  0,  32'd60, 1'b1);
        run_phase(84, 0,  32'd1, 1'b0);
        run_phase(0,  84, 32'hFFFF_FFFF, 1'b0);
        run_phase(14, 14, 32'($urandom_range(20, 500)), 1'b0);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/prrs_pkg.sv
design/prrs_slot_table.sv
design/priority_round_robin_scheduler.sv
test/prrs_scoreboard.sv
test/tb_priority_round_robin_scheduler.sv
